>>> hdl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN stack executor package
// Shared constants, types and helper functions of the RPN stack executor.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int STACK_DEPTH   = 64;
  localparam int NUM_VARIABLES = 64;
  localparam int VAR_AW        = $clog2(NUM_VARIABLES);
  localparam int NUM_ARRAYS    = 4;
  localparam int ARRAY_DEPTH   = 256;
  localparam int ARR_EW        = $clog2(ARRAY_DEPTH);
  localparam int ARRAY_TOTAL   = NUM_ARRAYS * ARRAY_DEPTH;
  localparam int ARR_AW        = $clog2(ARRAY_TOTAL);
  localparam int PROGRAM_DEPTH = 4096;
  localparam int POS_W         = 12;
  localparam int VAL_W         = 32;
  localparam int LIM_W         = 31;
  localparam int LEN_W         = 9;
  localparam int CFG_W         = 64;
  localparam int CFG_IW        = 3;
  localparam int ACT_W         = 5;
  localparam int ERR_W         = 4;

  typedef enum logic [1:0] {
    TAG_NUM  = 2'd0,
    TAG_VAR  = 2'd1,
    TAG_ARR  = 2'd2,
    TAG_ELEM = 2'd3
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [VAL_W-1:0] val;
  } entry_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_NUM = 5'd0,
    ACT_PUSH_VAR = 5'd1,
    ACT_PUSH_ARR = 5'd2,
    ACT_READ     = 5'd3,
    ACT_WRITE    = 5'd4,
    ACT_ADD      = 5'd5,
    ACT_SUB      = 5'd6,
    ACT_MUL      = 5'd7,
    ACT_DIV      = 5'd8,
    ACT_LT       = 5'd9,
    ACT_GT       = 5'd10,
    ACT_EQ       = 5'd11,
    ACT_LE       = 5'd12,
    ACT_GE       = 5'd13,
    ACT_NE       = 5'd14,
    ACT_ASSIGN   = 5'd15,
    ACT_JUMP     = 5'd16,
    ACT_JUMP_F   = 5'd17,
    ACT_INDEX    = 5'd18
  } act_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK         = 4'd0,
    ERR_UNKNOWN    = 4'd1,
    ERR_NO_INDEX   = 4'd2,
    ERR_EXP_VAR    = 4'd3,
    ERR_OVERFLOW   = 4'd4,
    ERR_DIV_ZERO   = 4'd5,
    ERR_NO_ARRAY   = 4'd6,
    ERR_IDX_RANGE  = 4'd7,
    ERR_UNDERFLOW  = 4'd8,
    ERR_STACK_FULL = 4'd9,
    ERR_BAD_JUMP   = 4'd10
  } err_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_LIMIT = 3'd0,
    CFG_MASK  = 3'd1,
    CFG_LEN0  = 3'd2,
    CFG_LEN1  = 3'd3,
    CFG_LEN2  = 3'd4,
    CFG_LEN3  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_TOP,
    ST_RD_SEC,
    ST_DEREF_TOP,
    ST_DEREF_SEC,
    ST_EVAL,
    ST_DIV_WAIT,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic ld;
    logic rd_sec;
    logic cap_top;
    logic cap_sec;
    logic cap_aval;
    logic eval;
    logic div_wait;
    logic commit;
    logic clr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    if (len > LEN_W'(ARRAY_DEPTH)) begin
      return LEN_W'(ARRAY_DEPTH);
    end
    return len;
  endfunction

  function automatic logic too_big(input logic [63:0] v, input logic [LIM_W-1:0] lim);
    logic [63:0] mag;
    mag = v[63] ? (~v + 64'd1) : v;
    return mag > {33'd0, lim};
  endfunction

endpackage

>>> hdl/rpn_stack_program_executor.sv
// ----------------------------------------------------------------------------
// RPN stack program executor
// Executes one reverse-Polish program request and returns one result.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake            | Payload
//   in_     | input     | in_valid / in_ready   | action, operand, read_value, position
//   out_    | output    | out_valid / out_ready | next_position, write_valid/value, error
//   cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// After acceptance a request passes through RD_TOP, RD_SEC, DEREF_TOP, DEREF_SEC,
// EVAL and COMMIT to a registered result; a division waits in DIV_WAIT between
// EVAL and COMMIT for the bit-serial divider. A new request is accepted only in IDLE.
// After reset the array store is zeroed by a clearing pass over all 1024 entries with
// in_ready low; configuration writes are taken during it.
// A result waiting on out_ready does not block acceptance of the next request;
// that request stalls only at its commit step until the output register frees.
module rpn_stack_program_executor #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         in_action,
  input  logic signed [31:0] in_operand,
  input  logic signed [31:0] in_read_value,
  input  logic [11:0]        in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        out_next_position,
  output logic               out_write_valid,
  output logic signed [31:0] out_write_value,
  output logic [3:0]         out_error,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  rpn_pkg::ctrl_cmd_t cmd;
  rpn_pkg::dp_stat_t  stat;

  rpn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  rpn_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_action(in_action), .in_operand(in_operand),
    .in_read_value(in_read_value), .in_position(in_position),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_next_position(out_next_position), .out_write_valid(out_write_valid),
    .out_write_value(out_write_value), .out_error(out_error)
  );

endmodule

>>> hdl/rpn_ram.sv
// ----------------------------------------------------------------------------
// RPN generic RAM
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/rpn_div.sv
// ----------------------------------------------------------------------------
// RPN divider
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rpn_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] dvd,
  input  logic signed [31:0] dvs,
  output logic               done,
  output logic signed [32:0] quo
);

  logic        busy_r;
  logic        done_r;
  logic        neg_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] den_r;
  logic [32:0] tmp;
  logic [32:0] ua;
  logic [32:0] ub;

  assign ua  = dvd[31] ? (33'd0 - {dvd[31], dvd}) : {1'b0, dvd};
  assign ub  = dvs[31] ? (33'd0 - {dvs[31], dvs}) : {1'b0, dvs};
  assign tmp = {rem_r, quo_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= ua[31:0];
      den_r <= ub[31:0];
      neg_r <= dvd[31] ^ dvs[31];
    end else if (busy_r) begin
      if (tmp >= {1'b0, den_r}) begin
        rem_r <= 32'(tmp - {1'b0, den_r});
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= tmp[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? $signed(33'd0 - {1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule

>>> hdl/rpn_ctrl.sv
// ----------------------------------------------------------------------------
// RPN controller
// Sequences the clearing pass and the fetch, evaluate, divider wait and commit steps.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpn_pkg::dp_stat_t stat,
  output rpn_pkg::ctrl_cmd_t cmd
);

  rpn_pkg::state_t state_r;
  rpn_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpn_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpn_pkg::ST_CLEAR: begin
        if (stat.clr_done) begin
          state_nxt = rpn_pkg::ST_IDLE;
        end
      end
      rpn_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = rpn_pkg::ST_RD_TOP;
        end
      end
      rpn_pkg::ST_RD_TOP:    state_nxt = rpn_pkg::ST_RD_SEC;
      rpn_pkg::ST_RD_SEC:    state_nxt = rpn_pkg::ST_DEREF_TOP;
      rpn_pkg::ST_DEREF_TOP: state_nxt = rpn_pkg::ST_DEREF_SEC;
      rpn_pkg::ST_DEREF_SEC: state_nxt = rpn_pkg::ST_EVAL;
      rpn_pkg::ST_EVAL: begin
        state_nxt = stat.need_div ? rpn_pkg::ST_DIV_WAIT : rpn_pkg::ST_COMMIT;
      end
      rpn_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = rpn_pkg::ST_COMMIT;
        end
      end
      rpn_pkg::ST_COMMIT: begin
        if (stat.out_free) begin
          state_nxt = rpn_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rpn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      rpn_pkg::ST_CLEAR: cmd.clr = 1'b1;
      rpn_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.ld   = in_valid;
      end
      rpn_pkg::ST_RD_SEC: begin
        cmd.rd_sec  = 1'b1;
        cmd.cap_top = 1'b1;
      end
      rpn_pkg::ST_DEREF_TOP: cmd.cap_sec  = 1'b1;
      rpn_pkg::ST_DEREF_SEC: cmd.cap_aval = 1'b1;
      rpn_pkg::ST_EVAL:      cmd.eval     = 1'b1;
      rpn_pkg::ST_DIV_WAIT:  cmd.div_wait = 1'b1;
      rpn_pkg::ST_COMMIT:    cmd.commit   = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/rpn_dp.sv
// ----------------------------------------------------------------------------
// RPN datapath
// Operand stack, variable and array stores, evaluation, divider and result.
// ----------------------------------------------------------------------------
module rpn_dp #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rpn_pkg::ctrl_cmd_t        cmd,
  output rpn_pkg::dp_stat_t         stat,
  input  logic [4:0]                in_action,
  input  logic signed [31:0]        in_operand,
  input  logic signed [31:0]        in_read_value,
  input  logic [11:0]               in_position,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [63:0]               cfg_wdata,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [11:0]               out_next_position,
  output logic                      out_write_valid,
  output logic signed [31:0]        out_write_value,
  output logic [3:0]                out_error
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int VAW = rpn_pkg::VAR_AW;
  localparam int AAW = rpn_pkg::ARR_AW;
  localparam int EW  = rpn_pkg::ARR_EW;

  logic [rpn_pkg::LIM_W-1:0] lim_r;
  logic [63:0]               mask_r;
  logic [rpn_pkg::LEN_W-1:0] alen_r [rpn_pkg::NUM_ARRAYS];

  rpn_pkg::act_t       act_r;
  logic [31:0]         op_r;
  logic [31:0]         rd_r;
  logic [11:0]         pos_r;
  rpn_pkg::entry_t     top_r;
  rpn_pkg::entry_t     sec_r;
  logic signed [31:0]  bval_r;
  logic signed [31:0]  aval_r;
  logic [SPW-1:0]      sp_r;
  logic [SPW-1:0]      sp_nxt;
  rpn_pkg::err_t       err_r;
  logic [63:0]         res_r;
  logic [11:0]         next_r;
  logic                wv_r;

  logic                out_valid_r;
  logic [11:0]         out_next_r;
  logic                out_wv_r;
  logic [31:0]         out_wval_r;
  rpn_pkg::err_t       out_err_r;

  logic [AAW-1:0]      clr_cnt_r;
  logic [rpn_pkg::NUM_VARIABLES-1:0] var_vld_r;
  logic                vvld_q;

  logic                stk_we;
  logic [SAW-1:0]      stk_waddr;
  rpn_pkg::entry_t     stk_wdata;
  logic [SAW-1:0]      stk_raddr;
  logic [33:0]         stk_rdata;
  rpn_pkg::entry_t     stk_ent;
  logic [SPW-1:0]      sp_m1;
  logic [SPW-1:0]      sp_m2;

  logic                var_we;
  logic [31:0]         var_q;
  logic                arr_we;
  logic [AAW-1:0]      arr_waddr;
  logic [31:0]         arr_wdata;
  logic [31:0]         arr_q;

  rpn_pkg::entry_t     sel_ent;
  logic [31:0]         dval;

  rpn_pkg::err_t       err_c;
  logic [63:0]         res_c;
  logic [11:0]         next_c;
  logic                wv_c;
  logic                need_div;
  logic                ge1;
  logic                ge2;
  logic                full;
  logic [31:0]         id_c;
  logic [rpn_pkg::LEN_W-1:0] len_c;
  logic [rpn_pkg::LEN_W-1:0] plen_c;
  logic signed [63:0]  prod_c;

  logic                div_done;
  logic signed [32:0]  div_q;

  logic                ovf;
  rpn_pkg::err_t       fin_err;
  logic                ok;
  logic                st_en;
  rpn_pkg::entry_t     st_ent;
  logic [31:0]         st_val;
  rpn_pkg::tag_t       push_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r  <= '1;
      mask_r <= '1;
      for (int i = 0; i < rpn_pkg::NUM_ARRAYS; i++) begin
        alen_r[i] <= rpn_pkg::LEN_W'(rpn_pkg::ARRAY_DEPTH);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        rpn_pkg::CFG_LIMIT: lim_r     <= cfg_wdata[rpn_pkg::LIM_W-1:0];
        rpn_pkg::CFG_MASK:  mask_r    <= cfg_wdata;
        rpn_pkg::CFG_LEN0:  alen_r[0] <= cfg_wdata[rpn_pkg::LEN_W-1:0];
        rpn_pkg::CFG_LEN1:  alen_r[1] <= cfg_wdata[rpn_pkg::LEN_W-1:0];
        rpn_pkg::CFG_LEN2:  alen_r[2] <= cfg_wdata[rpn_pkg::LEN_W-1:0];
        rpn_pkg::CFG_LEN3:  alen_r[3] <= cfg_wdata[rpn_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign sp_m1     = sp_r - SPW'(1);
  assign sp_m2     = sp_r - SPW'(2);
  assign stk_raddr = cmd.rd_sec ? sp_m2[SAW-1:0] : sp_m1[SAW-1:0];
  assign stk_ent   = rpn_pkg::entry_t'(stk_rdata);

  rpn_ram #(.WIDTH(34), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  rpn_ram #(.WIDTH(32), .DEPTH(rpn_pkg::NUM_VARIABLES)) u_vars (
    .clk(clk), .we(var_we), .waddr(st_ent.val[VAW-1:0]), .wdata(st_val),
    .raddr(stk_ent.val[VAW-1:0]), .rdata(var_q)
  );

  rpn_ram #(.WIDTH(32), .DEPTH(rpn_pkg::ARRAY_TOTAL)) u_arrays (
    .clk(clk), .we(arr_we), .waddr(arr_waddr), .wdata(arr_wdata),
    .raddr(stk_ent.val[AAW-1:0]), .rdata(arr_q)
  );

  always_ff @(posedge clk) begin
    vvld_q <= var_vld_r[stk_ent.val[VAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_vld_r <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (var_we) begin
        var_vld_r[st_ent.val[VAW-1:0]] <= 1'b1;
      end
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + AAW'(1);
      end
    end
  end

  assign sel_ent = cmd.cap_sec ? top_r : sec_r;

  always_comb begin
    case (sel_ent.tag)
      rpn_pkg::TAG_NUM:  dval = sel_ent.val;
      rpn_pkg::TAG_VAR: begin
        dval = (sel_ent.val < 32'(rpn_pkg::NUM_VARIABLES) && vvld_q) ? var_q : 32'd0;
      end
      rpn_pkg::TAG_ELEM: dval = (sel_ent.val < 32'(rpn_pkg::ARRAY_TOTAL)) ? arr_q : 32'd0;
      default:           dval = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      act_r <= rpn_pkg::act_t'(in_action);
      op_r  <= in_operand;
      rd_r  <= in_read_value;
      pos_r <= in_position;
    end
    if (cmd.cap_top) begin
      top_r <= stk_ent;
    end
    if (cmd.cap_sec) begin
      sec_r  <= stk_ent;
      bval_r <= dval;
    end
    if (cmd.cap_aval) begin
      aval_r <= dval;
    end
    if (cmd.eval) begin
      err_r  <= err_c;
      res_r  <= res_c;
      next_r <= next_c;
      wv_r   <= wv_c;
    end else if (cmd.div_wait && div_done) begin
      res_r <= 64'(div_q);
    end
  end

  assign ge1    = sp_r != '0;
  assign ge2    = sp_r > SPW'(1);
  assign full   = sp_r >= SPW'(STACK_DEPTH);
  assign id_c   = (sec_r.tag == rpn_pkg::TAG_ELEM) ? (sec_r.val >> EW) : sec_r.val;
  assign len_c  = (id_c < 32'(rpn_pkg::NUM_ARRAYS)) ? rpn_pkg::eff_len(alen_r[id_c[1:0]]) : '0;
  assign plen_c = (op_r < 32'(rpn_pkg::NUM_ARRAYS)) ? rpn_pkg::eff_len(alen_r[op_r[1:0]]) : '0;
  assign prod_c = aval_r * bval_r;

  always_comb begin
    err_c    = rpn_pkg::ERR_OK;
    res_c    = '0;
    next_c   = pos_r + 12'd1;
    wv_c     = 1'b0;
    need_div = 1'b0;
    case (act_r)
      rpn_pkg::ACT_PUSH_NUM, rpn_pkg::ACT_PUSH_VAR, rpn_pkg::ACT_PUSH_ARR: begin
        if (full) begin
          err_c = rpn_pkg::ERR_STACK_FULL;
        end else if (act_r == rpn_pkg::ACT_PUSH_VAR &&
                     (op_r >= 32'(rpn_pkg::NUM_VARIABLES) || !mask_r[op_r[VAW-1:0]])) begin
          err_c = rpn_pkg::ERR_UNKNOWN;
        end else if (act_r == rpn_pkg::ACT_PUSH_ARR && plen_c == '0) begin
          err_c = rpn_pkg::ERR_UNKNOWN;
        end
      end
      rpn_pkg::ACT_READ: begin
        if (!ge1) begin
          err_c = rpn_pkg::ERR_UNDERFLOW;
        end else if (rpn_pkg::too_big({{32{rd_r[31]}}, rd_r}, lim_r)) begin
          err_c = rpn_pkg::ERR_OVERFLOW;
        end else if (top_r.tag == rpn_pkg::TAG_NUM) begin
          err_c = rpn_pkg::ERR_EXP_VAR;
        end else if (top_r.tag == rpn_pkg::TAG_ARR) begin
          err_c = rpn_pkg::ERR_NO_INDEX;
        end
      end
      rpn_pkg::ACT_WRITE: begin
        if (!ge1) begin
          err_c = rpn_pkg::ERR_UNDERFLOW;
        end else if (top_r.tag == rpn_pkg::TAG_ARR) begin
          err_c = rpn_pkg::ERR_NO_INDEX;
        end else begin
          wv_c = 1'b1;
        end
      end
      rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV,
      rpn_pkg::ACT_LT, rpn_pkg::ACT_GT, rpn_pkg::ACT_EQ, rpn_pkg::ACT_LE,
      rpn_pkg::ACT_GE, rpn_pkg::ACT_NE: begin
        if (!ge2) begin
          err_c = rpn_pkg::ERR_UNDERFLOW;
        end else if (act_r == rpn_pkg::ACT_DIV) begin
          if (top_r.tag == rpn_pkg::TAG_ARR) begin
            err_c = rpn_pkg::ERR_NO_INDEX;
          end else if (bval_r == 32'sd0) begin
            err_c = rpn_pkg::ERR_DIV_ZERO;
          end else if (sec_r.tag == rpn_pkg::TAG_ARR) begin
            err_c = rpn_pkg::ERR_NO_INDEX;
          end else begin
            need_div = 1'b1;
          end
        end else if (sec_r.tag == rpn_pkg::TAG_ARR || top_r.tag == rpn_pkg::TAG_ARR) begin
          err_c = rpn_pkg::ERR_NO_INDEX;
        end
        case (act_r)
          rpn_pkg::ACT_ADD: res_c = {{32{aval_r[31]}}, aval_r} + {{32{bval_r[31]}}, bval_r};
          rpn_pkg::ACT_SUB: res_c = {{32{aval_r[31]}}, aval_r} - {{32{bval_r[31]}}, bval_r};
          rpn_pkg::ACT_MUL: res_c = prod_c;
          rpn_pkg::ACT_LT:  res_c = {63'd0, aval_r < bval_r};
          rpn_pkg::ACT_GT:  res_c = {63'd0, aval_r > bval_r};
          rpn_pkg::ACT_EQ:  res_c = {63'd0, aval_r == bval_r};
          rpn_pkg::ACT_LE:  res_c = {63'd0, aval_r <= bval_r};
          rpn_pkg::ACT_GE:  res_c = {63'd0, aval_r >= bval_r};
          rpn_pkg::ACT_NE:  res_c = {63'd0, aval_r != bval_r};
          default:          res_c = '0;
        endcase
      end
      rpn_pkg::ACT_ASSIGN: begin
        if (!ge2) begin
          err_c = rpn_pkg::ERR_UNDERFLOW;
        end else if (sec_r.tag == rpn_pkg::TAG_NUM) begin
          err_c = rpn_pkg::ERR_EXP_VAR;
        end else if (sec_r.tag == rpn_pkg::TAG_ARR || top_r.tag == rpn_pkg::TAG_ARR) begin
          err_c = rpn_pkg::ERR_NO_INDEX;
        end
      end
      rpn_pkg::ACT_JUMP, rpn_pkg::ACT_JUMP_F: begin
        if (act_r == rpn_pkg::ACT_JUMP ? !ge1 : !ge2) begin
          err_c = rpn_pkg::ERR_UNDERFLOW;
        end else if (act_r == rpn_pkg::ACT_JUMP_F && sec_r.tag == rpn_pkg::TAG_ARR) begin
          err_c = rpn_pkg::ERR_NO_INDEX;
        end else if (act_r == rpn_pkg::ACT_JUMP || aval_r == 32'sd0) begin
          if (top_r.tag == rpn_pkg::TAG_ARR) begin
            err_c = rpn_pkg::ERR_NO_INDEX;
          end else if (bval_r[31] || bval_r[30:0] >= 31'(rpn_pkg::PROGRAM_DEPTH)) begin
            err_c = rpn_pkg::ERR_BAD_JUMP;
          end else begin
            next_c = bval_r[11:0];
          end
        end
      end
      rpn_pkg::ACT_INDEX: begin
        if (!ge2) begin
          err_c = rpn_pkg::ERR_UNDERFLOW;
        end else if (sec_r.tag == rpn_pkg::TAG_NUM) begin
          err_c = rpn_pkg::ERR_EXP_VAR;
        end else if (sec_r.tag == rpn_pkg::TAG_VAR || len_c == '0) begin
          err_c = rpn_pkg::ERR_NO_ARRAY;
        end else if (top_r.tag == rpn_pkg::TAG_ARR) begin
          err_c = rpn_pkg::ERR_NO_INDEX;
        end else if (bval_r[31] || 32'(bval_r) >= 32'(len_c)) begin
          err_c = rpn_pkg::ERR_IDX_RANGE;
        end
        res_c = 64'({id_c[1:0], bval_r[EW-1:0]});
      end
      default: ;
    endcase
  end

  rpn_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.eval && need_div),
    .dvd(aval_r), .dvs(bval_r), .done(div_done), .quo(div_q)
  );

  assign ovf = (act_r == rpn_pkg::ACT_ADD || act_r == rpn_pkg::ACT_SUB ||
                act_r == rpn_pkg::ACT_MUL || act_r == rpn_pkg::ACT_DIV) &&
               err_r == rpn_pkg::ERR_OK && rpn_pkg::too_big(res_r, lim_r);
  assign fin_err = ovf ? rpn_pkg::ERR_OVERFLOW : err_r;
  assign ok      = fin_err == rpn_pkg::ERR_OK;

  assign st_en  = cmd.commit && ok &&
                  (act_r == rpn_pkg::ACT_READ || act_r == rpn_pkg::ACT_ASSIGN);
  assign st_ent = (act_r == rpn_pkg::ACT_READ) ? top_r : sec_r;
  assign st_val = (act_r == rpn_pkg::ACT_READ) ? rd_r : bval_r;
  assign var_we = st_en && st_ent.tag == rpn_pkg::TAG_VAR &&
                  st_ent.val < 32'(rpn_pkg::NUM_VARIABLES);
  assign arr_we = cmd.clr || (st_en && st_ent.tag == rpn_pkg::TAG_ELEM &&
                  st_ent.val < 32'(rpn_pkg::ARRAY_TOTAL));
  assign arr_waddr = cmd.clr ? clr_cnt_r : st_ent.val[AAW-1:0];
  assign arr_wdata = cmd.clr ? 32'd0 : st_val;

  assign push_tag = (act_r == rpn_pkg::ACT_PUSH_NUM) ? rpn_pkg::TAG_NUM :
                    (act_r == rpn_pkg::ACT_PUSH_VAR) ? rpn_pkg::TAG_VAR : rpn_pkg::TAG_ARR;

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sp_m2[SAW-1:0];
    stk_wdata = '{tag: rpn_pkg::TAG_NUM, val: res_r[31:0]};
    sp_nxt    = sp_r;
    case (act_r)
      rpn_pkg::ACT_PUSH_NUM, rpn_pkg::ACT_PUSH_VAR, rpn_pkg::ACT_PUSH_ARR: begin
        stk_we    = 1'b1;
        stk_waddr = sp_r[SAW-1:0];
        stk_wdata = '{tag: push_tag, val: op_r};
        sp_nxt    = sp_r + SPW'(1);
      end
      rpn_pkg::ACT_READ, rpn_pkg::ACT_WRITE, rpn_pkg::ACT_JUMP: sp_nxt = sp_m1;
      rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV,
      rpn_pkg::ACT_LT, rpn_pkg::ACT_GT, rpn_pkg::ACT_EQ, rpn_pkg::ACT_LE,
      rpn_pkg::ACT_GE, rpn_pkg::ACT_NE: begin
        stk_we = 1'b1;
        sp_nxt = sp_m1;
      end
      rpn_pkg::ACT_INDEX: begin
        stk_we    = 1'b1;
        stk_wdata = '{tag: rpn_pkg::TAG_ELEM, val: res_r[31:0]};
        sp_nxt    = sp_m1;
      end
      rpn_pkg::ACT_ASSIGN, rpn_pkg::ACT_JUMP_F: sp_nxt = sp_m2;
      default: ;
    endcase
    if (!(cmd.commit && ok)) begin
      stk_we = 1'b0;
      sp_nxt = sp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r <= sp_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_next_r <= ok ? next_r : pos_r;
      out_wv_r   <= ok && wv_r;
      out_wval_r <= (ok && wv_r) ? bval_r : 32'd0;
      out_err_r  <= fin_err;
    end
  end

  assign stat.clr_done = clr_cnt_r == AAW'(rpn_pkg::ARRAY_TOTAL - 1);
  assign stat.need_div = need_div;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_next_position = out_next_r;
  assign out_write_valid   = out_wv_r;
  assign out_write_value   = out_wval_r;
  assign out_error         = out_err_r;

endmodule

>>> hdl/rpn_chk.sv
// ----------------------------------------------------------------------------
// RPN port checker
// Assertions on the executor's ports, bound to the top level.
// ----------------------------------------------------------------------------
module rpn_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_write_valid,
  input logic [31:0] out_write_value,
  input logic [3:0]  out_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result dropped before it was taken.");

  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error != rpn_pkg::ERR_OK |-> !out_write_valid)
    else $error("Failed request reports a written value.");

  a_idle_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_write_value == 32'd0)
    else $error("Write value is nonzero without a write.");

  a_clear_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_ready && !out_valid)
    else $error("Request taken during the clearing pass.");

endmodule

bind rpn_stack_program_executor rpn_chk u_rpn_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_write_valid(out_write_valid),
  .out_write_value(out_write_value), .out_error(out_error)
);
